// ===== src/connection_throttle_table_unit_defines.svh =====
// Assertion macros for the connection throttle table unit.
// Used by the port checker; expects clock and reset in scope.
`ifndef CONNECTION_THROTTLE_TABLE_UNIT_DEFINES_SVH
`define CONNECTION_THROTTLE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define CTT_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("connection throttle check failed");

// next-cycle implication, off during reset
`define CTT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("connection throttle check failed");

`endif

// ===== src/ctt_pkg.sv =====
// Shared types, codes and the ban length table of the connection throttle.
// No dependencies.
package ctt_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int KEY_BITS_DEF      = 64;
   localparam int TIME_BITS_DEF     = 32;
   localparam int QUEUE_DEPTH       = 2;

   // command codes
   localparam logic [1:0] CMD_CHECK  = 2'd0;
   localparam logic [1:0] CMD_FORCE  = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_ENABLE      = 2'd0;
   localparam logic [1:0] CSR_TRIG_COUNT  = 2'd1;
   localparam logic [1:0] CSR_TRIG_WINDOW = 2'd2;
   localparam logic [1:0] CSR_RECORD_HOLD = 2'd3;

   localparam logic [8:0] FORCED_MARK = 9'd511;
   localparam logic [8:0] COUNT_SAT   = 9'd255;
   localparam logic [2:0] STAGE_MAX   = 3'd7;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]  cmd;
      logic        bypass;
      logic [63:0] key;
      logic [31:0] now_time;
      logic [31:0] son_time;
      logic        remote;
   } cmd_type;

   // one result transaction
   typedef struct packed {
      logic        allowed;
      logic        ban_placed;
      logic [11:0] ban_seconds;
      logic        longer_next;
      logic [2:0]  offense_number;
      logic [7:0]  conn_count;
      logic        table_full;
      logic [6:0]  removed_count;
   } rsp_type;

   function automatic logic [11:0] ban_length(input logic [2:0] stage);
      logic [11:0] len;
      case (stage)
         3'd0:    len = 12'd0;
         3'd1:    len = 12'd120;
         3'd2:    len = 12'd300;
         3'd3:    len = 12'd900;
         3'd4:    len = 12'd1800;
         default: len = 12'd3600;
      endcase
      return len;
   endfunction

endpackage

// ===== src/ctt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ctt_front.sv =====
// Front end: accepts command transactions, classifies them and queues them.
// Depends on ctt_pkg.
module ctt_front #(
   parameter int TIME_BITS = ctt_pkg::TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_cmd,
   input  logic [63:0]      req_addr_key,
   input  logic [31:0]      req_now_time,
   input  logic [31:0]      req_sign_on_time,
   input  logic             req_is_remote,
   input  logic             req_is_exempt,
   input  logic             cfg_enable,
   input  logic [15:0]      cfg_window,
   output logic             cmd_valid,
   output ctt_pkg::cmd_type cmd_out,
   input  logic             cmd_take
);

   localparam int QD   = ctt_pkg::QUEUE_DEPTH;
   localparam int QP_W = (QD > 1) ? $clog2(QD) : 1;
   localparam int QC_W = $clog2(QD + 1);
   localparam int TW1  = TIME_BITS + 1;

   logic [TIME_BITS-1:0] now_m;
   logic [TIME_BITS-1:0] son_m;
   logic [TIME_BITS-1:0] son_c;
   logic                 old_remote;
   logic                 bypass;
   ctt_pkg::cmd_type     item;

   ctt_pkg::cmd_type q_ff [QD];
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   // classify: stale remote sign-on, exempt, disabled
   always_comb begin
      now_m      = TIME_BITS'(req_now_time);
      son_m      = TIME_BITS'(req_sign_on_time);
      old_remote = req_is_remote && (now_m >= son_m) &&
                   (TW1'(now_m - son_m) > TW1'(cfg_window));
      son_c      = (son_m > now_m) ? now_m : son_m;
      bypass     = ((req_cmd == ctt_pkg::CMD_CHECK) &&
                    (!cfg_enable || old_remote || req_is_exempt)) ||
                   ((req_cmd == ctt_pkg::CMD_TICK) && !cfg_enable);
      item.cmd      = req_cmd;
      item.bypass   = bypass;
      item.key      = req_addr_key;
      item.now_time = 32'(now_m);
      item.son_time = 32'(son_c);
      item.remote   = req_is_remote;
   end

   // command queue
   assign req_full  = (count_ff == QC_W'(QD));
   assign cmd_valid = (count_ff != '0);
   assign cmd_out   = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== src/ctt_back.sv =====
// Back end: scans the record table one entry a cycle, applies the command
// and holds the result transaction. Depends on ctt_pkg and ctt_ram.
module ctt_back #(
   parameter int TABLE_ENTRIES = ctt_pkg::TABLE_ENTRIES_DEF,
   parameter int KEY_BITS      = ctt_pkg::KEY_BITS_DEF,
   parameter int TIME_BITS     = ctt_pkg::TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  ctt_pkg::cmd_type cmd_in,
   output logic             cmd_take,
   input  logic [7:0]       cfg_trigger,
   input  logic [15:0]      cfg_window,
   input  logic [15:0]      cfg_hold,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output ctt_pkg::rsp_type rsp_out
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int TW1   = TIME_BITS + 1;
   localparam int REC_W = KEY_BITS + 9 + 3 * TIME_BITS + 1 + 3;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]             state_ff, state_in;
   ctt_pkg::cmd_type       cur_ff, cur_in;
   logic [CNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [REC_W-1:0]       hit_rec_ff, hit_rec_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]       kill_cnt_ff, kill_cnt_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                   out_valid_ff, out_valid_in;
   ctt_pkg::rsp_type       res_ff, res_in;

   logic [IDX_W-1:0]       rd_addr;
   logic [REC_W-1:0]       rd_data;
   logic                   wr_en;
   logic [REC_W-1:0]       wr_data;

   // fields of the record being read
   logic [KEY_BITS-1:0]    r_key;
   logic [TIME_BITS-1:0]   r_ls, r_bb;
   logic                   r_ba;
   logic [2:0]             r_st;
   // fields of the matched record
   logic [8:0]             h_cnt;
   logic [TIME_BITS-1:0]   h_ws, h_ls, h_bb;
   logic                   h_ba;
   logic [2:0]             h_st;

   logic [KEY_BITS-1:0]    key_m;
   logic [TIME_BITS-1:0]   now_t, son_t;
   logic                   out_free;
   logic                   commit;
   logic                   kill;
   logic [16:0]            kill_lim;

   // exec results
   ctt_pkg::rsp_type       ex_res;
   logic                   ex_wr;
   logic                   ex_set;
   logic                   ex_clr;
   logic [IDX_W-1:0]       ex_idx;
   logic [8:0]             n_cnt;
   logic [TIME_BITS-1:0]   n_ws, n_ls, n_bb;
   logic                   n_ba;
   logic [2:0]             n_st;

   // record layout: {key, count, window start, last seen, ban begin, ban, stage}
   assign r_key = rd_data[REC_W-1 -: KEY_BITS];
   assign r_ls  = rd_data[4 + TIME_BITS +: TIME_BITS];
   assign r_bb  = rd_data[4 +: TIME_BITS];
   assign r_ba  = rd_data[3];
   assign r_st  = rd_data[2:0];
   assign {h_cnt, h_ws, h_ls, h_bb, h_ba, h_st} = hit_rec_ff[REC_W-KEY_BITS-1:0];

   assign key_m    = KEY_BITS'(cur_ff.key);
   assign now_t    = TIME_BITS'(cur_ff.now_time);
   assign son_t    = TIME_BITS'(cur_ff.son_time);
   assign out_free = !out_valid_ff || rsp_pop;
   assign commit   = (state_ff == ST_EXEC) && out_free;
   assign rsp_empty = !out_valid_ff;
   assign rsp_out   = res_ff;

   ctt_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ex_idx),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // expiry decision for the entry coming out of the RAM
   always_comb begin
      kill_lim = 17'(ctt_pkg::ban_length(r_st)) + 17'(cfg_hold);
      if (now_t == '0) begin
         kill = 1'b1;
      end else if (r_ba) begin
         kill = (now_t >= r_bb) && (TW1'(now_t - r_bb) >= TW1'(kill_lim));
      end else begin
         kill = (now_t >= r_ls) && (TW1'(now_t - r_ls) >= TW1'(cfg_hold));
      end
   end

   // apply the command to the matched or allocated record
   always_comb begin
      logic [11:0] len;
      logic [2:0]  s;
      logic        done;
      ex_res         = '0;
      ex_res.allowed = 1'b1;
      ex_wr          = 1'b0;
      ex_set         = 1'b0;
      ex_clr         = 1'b0;
      ex_idx         = found_ff ? hit_idx_ff : free_idx_ff;
      done           = 1'b0;
      len            = '0;
      s              = '0;
      if (found_ff) begin
         n_cnt = h_cnt;
         n_ws  = h_ws;
         n_ls  = h_ls;
         n_bb  = h_bb;
         n_ba  = h_ba;
         n_st  = h_st;
      end else begin
         n_cnt = '0;
         n_ws  = '0;
         n_ls  = '0;
         n_bb  = '0;
         n_ba  = 1'b0;
         n_st  = '0;
      end
      case (cur_ff.cmd)
         ctt_pkg::CMD_CHECK: begin
            if (cur_ff.bypass) begin
               done = 1'b1;
            end else if (!found_ff && !free_ff) begin
               ex_res.table_full = 1'b1;
            end else begin
               ex_wr  = 1'b1;
               ex_set = 1'b1;
               if (!found_ff) begin
                  n_ws = son_t;
               end
               // retry during a ban
               if (found_ff && h_ba) begin
                  len = ctt_pkg::ban_length(h_st);
                  if (!((son_t >= h_bb) && (TW1'(son_t - h_bb) >= TW1'(len)))) begin
                     ex_res.allowed    = 1'b0;
                     ex_res.conn_count = (h_cnt == ctt_pkg::FORCED_MARK) ? 8'd0 : h_cnt[7:0];
                     if (!cur_ff.remote) begin
                        n_bb = son_t;
                     end
                     done = 1'b1;
                  end else begin
                     n_cnt = '0;
                     n_ws  = son_t;
                     n_ba  = 1'b0;
                  end
               end
               if (!done) begin
                  if ((n_cnt != ctt_pkg::FORCED_MARK) && (n_cnt < ctt_pkg::COUNT_SAT)) begin
                     n_cnt = n_cnt + 9'd1;
                  end
                  n_ls = son_t;
                  if ((son_t >= n_ws) && (TW1'(son_t - n_ws) > TW1'(cfg_window))) begin
                     // window ran out: restart counting
                     n_cnt = 9'd1;
                     n_ws  = son_t;
                     ex_res.conn_count = 8'd1;
                  end else if (n_cnt == ctt_pkg::FORCED_MARK) begin
                     ex_res.allowed = 1'b0;
                  end else begin
                     ex_res.conn_count = n_cnt[7:0];
                     if (n_cnt >= {1'b0, cfg_trigger}) begin
                        ex_res.allowed = 1'b0;
                        if (!cur_ff.remote) begin
                           s = (h_st == ctt_pkg::STAGE_MAX) ? h_st : h_st + 3'd1;
                           if (!found_ff) begin
                              s = 3'd1;
                           end
                           n_st = s;
                           n_bb = son_t;
                           n_ba = 1'b1;
                           ex_res.ban_placed     = 1'b1;
                           ex_res.ban_seconds    = ctt_pkg::ban_length(s);
                           ex_res.longer_next    =
                              ctt_pkg::ban_length((s == ctt_pkg::STAGE_MAX) ? s : s + 3'd1)
                              != ctt_pkg::ban_length(s);
                           ex_res.offense_number = s;
                        end
                     end
                  end
               end
            end
         end
         ctt_pkg::CMD_FORCE: begin
            if (!found_ff && !free_ff) begin
               ex_res.table_full = 1'b1;
            end else begin
               ex_wr  = 1'b1;
               ex_set = 1'b1;
               n_cnt  = ctt_pkg::FORCED_MARK;
               n_ls   = now_t;
               n_ws   = now_t;
            end
         end
         ctt_pkg::CMD_REMOVE: begin
            if (found_ff) begin
               ex_clr               = 1'b1;
               ex_res.removed_count = 7'd1;
            end
         end
         default: begin
            if (!cur_ff.bypass) begin
               ex_res.removed_count = 7'(kill_cnt_ff);
            end
         end
      endcase
   end

   assign wr_en   = commit && ex_wr;
   assign wr_data = {key_m, n_cnt, n_ws, n_ls, n_bb, n_ba, n_st};

   // sequencer: take, scan, execute
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rec_in   = hit_rec_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      kill_cnt_in  = kill_cnt_ff;
      valid_in     = valid_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      res_in       = res_ff;
      cmd_take     = 1'b0;
      rd_addr      = scan_idx_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take    = 1'b1;
               cur_in      = cmd_in;
               scan_idx_in = '0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               kill_cnt_in = '0;
               state_in    = cmd_in.bypass ? ST_EXEC : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff != CNT_W'(TABLE_ENTRIES)) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_EXEC;
            end
            if (pend_ff) begin
               if (cur_ff.cmd == ctt_pkg::CMD_TICK) begin
                  if (valid_ff[pend_idx_ff] && kill) begin
                     valid_in[pend_idx_ff] = 1'b0;
                     kill_cnt_in           = kill_cnt_ff + 1'b1;
                  end
               end else begin
                  if (valid_ff[pend_idx_ff] && (r_key == key_m) && !found_ff) begin
                     found_in   = 1'b1;
                     hit_idx_in = pend_idx_ff;
                     hit_rec_in = rd_data;
                  end
                  if (!valid_ff[pend_idx_ff] && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = pend_idx_ff;
                  end
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               res_in       = ex_res;
               state_in     = ST_IDLE;
               if (ex_set) begin
                  valid_in[ex_idx] = 1'b1;
               end
               if (ex_clr) begin
                  valid_in[ex_idx] = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      scan_idx_ff <= scan_idx_in;
      pend_idx_ff <= pend_idx_in;
      found_ff    <= found_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rec_ff  <= hit_rec_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      kill_cnt_ff <= kill_cnt_in;
      res_ff      <= res_in;
   end

endmodule

// ===== src/connection_throttle_table_unit.sv =====
// Top level of the connection throttle table: register file, front and back.
// Depends on ctt_pkg, ctt_front, ctt_back.
//
// Commands enter through a queue-style port (push/full) and results leave
// through one (empty/pop), one result transaction per command, in order.
// Check, force, remove and tick each sweep the whole record table through the
// single read port of the record RAM, one entry per cycle; a check that is
// admitted without lookup (disabled, exempt, stale remote) and a tick while
// disabled skip the sweep. A two-deep command queue in front of the table
// engine accepts new commands while one is being worked on, and the result
// register lets the next command start before the last result is taken.
// Registers are written through the csr port, which is always ready.
module connection_throttle_table_unit #(
   parameter int TABLE_ENTRIES = ctt_pkg::TABLE_ENTRIES_DEF,
   parameter int KEY_BITS      = ctt_pkg::KEY_BITS_DEF,
   parameter int TIME_BITS     = ctt_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // command side
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_addr_key,
   input  logic [31:0] req_now_time,
   input  logic [31:0] req_sign_on_time,
   input  logic        req_is_remote,
   input  logic        req_is_exempt,
   // result side
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_allowed,
   output logic        rsp_ban_placed,
   output logic [11:0] rsp_ban_seconds,
   output logic        rsp_longer_next,
   output logic [2:0]  rsp_offense_number,
   output logic [7:0]  rsp_conn_count,
   output logic        rsp_table_full,
   output logic [6:0]  rsp_removed_count,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic             enable_ff,  enable_in;
   logic [7:0]       trigger_ff, trigger_in;
   logic [15:0]      window_ff,  window_in;
   logic [15:0]      hold_ff,    hold_in;
   logic             cmd_valid;
   logic             cmd_take;
   ctt_pkg::cmd_type cmd;
   ctt_pkg::rsp_type rsp;

   // register file
   assign csr_ready = 1'b1;

   always_comb begin
      enable_in  = enable_ff;
      trigger_in = trigger_ff;
      window_in  = window_ff;
      hold_in    = hold_ff;
      if (csr_valid) begin
         case (csr_index)
            ctt_pkg::CSR_ENABLE:      enable_in  = csr_data[0];
            ctt_pkg::CSR_TRIG_COUNT:  trigger_in = csr_data[7:0];
            ctt_pkg::CSR_TRIG_WINDOW: window_in  = csr_data;
            ctt_pkg::CSR_RECORD_HOLD: hold_in    = csr_data;
            default:                  enable_in  = enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         trigger_ff <= 8'd3;
         window_ff  <= 16'd60;
         hold_ff    <= 16'd1800;
      end else begin
         enable_ff  <= enable_in;
         trigger_ff <= trigger_in;
         window_ff  <= window_in;
         hold_ff    <= hold_in;
      end
   end

   ctt_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_addr_key     (req_addr_key),
      .req_now_time     (req_now_time),
      .req_sign_on_time (req_sign_on_time),
      .req_is_remote    (req_is_remote),
      .req_is_exempt    (req_is_exempt),
      .cfg_enable       (enable_ff),
      .cfg_window       (window_ff),
      .cmd_valid        (cmd_valid),
      .cmd_out          (cmd),
      .cmd_take         (cmd_take)
   );

   ctt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS),
      .TIME_BITS     (TIME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_in      (cmd),
      .cmd_take    (cmd_take),
      .cfg_trigger (trigger_ff),
      .cfg_window  (window_ff),
      .cfg_hold    (hold_ff),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_out     (rsp)
   );

   assign rsp_allowed        = rsp.allowed;
   assign rsp_ban_placed     = rsp.ban_placed;
   assign rsp_ban_seconds    = rsp.ban_seconds;
   assign rsp_longer_next    = rsp.longer_next;
   assign rsp_offense_number = rsp.offense_number;
   assign rsp_conn_count     = rsp.conn_count;
   assign rsp_table_full     = rsp.table_full;
   assign rsp_removed_count  = rsp.removed_count;

endmodule

// ===== src/ctt_assert.sv =====
// Port-level checks of the connection throttle table unit, bound to the top.
// Depends on connection_throttle_table_unit_defines.svh.
`include "connection_throttle_table_unit_defines.svh"

module ctt_assert (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [1:0]  req_cmd,
   input logic [63:0] req_addr_key,
   input logic [31:0] req_now_time,
   input logic [31:0] req_sign_on_time,
   input logic        req_is_remote,
   input logic        req_is_exempt,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_allowed,
   input logic        rsp_ban_placed,
   input logic [11:0] rsp_ban_seconds,
   input logic        rsp_longer_next,
   input logic [2:0]  rsp_offense_number,
   input logic [7:0]  rsp_conn_count,
   input logic        rsp_table_full,
   input logic [6:0]  rsp_removed_count,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);

   // a new ban always drops and reports a length and offense
   `CTT_ASSERT_IMPLY(a_ban_drops, !rsp_empty && rsp_ban_placed, !rsp_allowed && rsp_ban_seconds != 12'd0 && rsp_offense_number != 3'd0)

   // full table admits and never bans
   `CTT_ASSERT_IMPLY(a_full_admits, !rsp_empty && rsp_table_full, rsp_allowed && !rsp_ban_placed)

   // deletions come only from remove or tick
   `CTT_ASSERT_IMPLY(a_removed_only, !rsp_empty && rsp_removed_count != 7'd0, rsp_allowed && rsp_conn_count == 8'd0 && !rsp_ban_placed)

   // an untaken result stays
   `CTT_ASSERT_NEXT(a_rsp_holds, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_conn_count))

endmodule

bind connection_throttle_table_unit ctt_assert u_ctt_assert (.*);
